FILE: design/ppa_pkg.sv
// ----------------------------------------------------------------------------
// ppa_pkg - shared types and constants for the pixel point ALU
// Opcodes, pixel limits and the beat record handed from cell to cell.
// ----------------------------------------------------------------------------
package ppa_pkg;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned OP_W    = 4;
  localparam int unsigned N_CELLS = PIX_W;  // one quotient bit per cell

  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

  typedef enum logic [OP_W-1:0] {
    OP_SET       = 4'd0,
    OP_ADD       = 4'd1,
    OP_SUB       = 4'd2,
    OP_MUL       = 4'd3,
    OP_DIV       = 4'd4,
    OP_MAX       = 4'd5,
    OP_MIN       = 4'd6,
    OP_AVG       = 4'd7,
    OP_THRESHOLD = 4'd8
  } ppa_op_t;

  // One beat in flight. Non-divide results are final at the front stage;
  // divides carry remainder and the dividend/quotient shift word.
  typedef struct packed {
    logic             is_div;
    logic             dz;
    logic [PIX_W-1:0] divisor;
    logic [PIX_W-1:0] rem;
    logic [PIX_W-1:0] aq;
    logic [PIX_W-1:0] result;
  } ppa_beat_t;

endpackage

FILE: design/ppa_front.sv
// ----------------------------------------------------------------------------
// ppa_front - operand select and point operations
// Registers one beat; sets up the divide state for the cell chain.
// ----------------------------------------------------------------------------
module ppa_front import ppa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [OP_W-1:0]  opcode,
  input  logic [PIX_W-1:0] first_pixel,
  input  logic [PIX_W-1:0] second_pixel,
  input  logic             use_scalar,
  input  logic [PIX_W-1:0] scalar_value,
  output logic             out_valid,
  input  logic             out_ready,
  output ppa_beat_t        out_beat
);

  logic [PIX_W-1:0]   b;
  logic [PIX_W:0]     sum;
  logic [2*PIX_W-1:0] prod;
  ppa_beat_t          beat_next;

  assign b    = use_scalar ? scalar_value : second_pixel;
  assign sum  = {1'b0, first_pixel} + {1'b0, b};
  assign prod = {{PIX_W{1'b0}}, first_pixel} * {{PIX_W{1'b0}}, b};

  always_comb begin
    beat_next         = '0;
    beat_next.divisor = scalar_value;
    beat_next.aq      = first_pixel;
    case (opcode)
      OP_SET:       beat_next.result = scalar_value;
      OP_ADD:       beat_next.result = sum[PIX_W] ? PIX_MAX : sum[PIX_W-1:0];
      OP_SUB:       beat_next.result = (first_pixel > b) ? first_pixel - b : '0;
      OP_MUL:       beat_next.result = prod[2*PIX_W-1:PIX_W];
      OP_DIV: begin
        beat_next.is_div = 1'b1;
        beat_next.dz     = (scalar_value == '0);
      end
      OP_MAX:       beat_next.result = (first_pixel > b) ? first_pixel : b;
      OP_MIN:       beat_next.result = (first_pixel < b) ? first_pixel : b;
      OP_AVG:       beat_next.result = sum[PIX_W:1];
      OP_THRESHOLD: beat_next.result = {{(PIX_W-1){1'b0}}, first_pixel > scalar_value};
      default:      beat_next.result = first_pixel;
    endcase
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_beat <= beat_next;
    end
  end

endmodule

FILE: design/ppa_div_cell.sv
// ----------------------------------------------------------------------------
// ppa_div_cell - one restoring-division step
// Shifts one dividend bit into the remainder and one quotient bit out.
// ----------------------------------------------------------------------------
module ppa_div_cell import ppa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ppa_beat_t in_beat,
  output logic      out_valid,
  input  logic      out_ready,
  output ppa_beat_t out_beat
);

  logic [PIX_W:0] trial;
  logic [PIX_W:0] diff;
  logic           q_bit;
  ppa_beat_t      beat_next;

  assign trial = {in_beat.rem, in_beat.aq[PIX_W-1]};
  assign diff  = trial - {1'b0, in_beat.divisor};
  assign q_bit = (trial >= {1'b0, in_beat.divisor});

  always_comb begin
    beat_next = in_beat;
    if (in_beat.is_div) begin
      beat_next.rem = q_bit ? diff[PIX_W-1:0] : trial[PIX_W-1:0];
      beat_next.aq  = {in_beat.aq[PIX_W-2:0], q_bit};
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_beat <= beat_next;
    end
  end

endmodule

FILE: design/pixel_point_alu.sv
// ----------------------------------------------------------------------------
// pixel_point_alu - saturating 8-bit per-pixel point operation unit
// Pipeline: an accepted s_ beat passes nine registers (front stage plus eight
//   division cells) on its way to m_tvalid, the same for every opcode.
// Throughput: one beat per cycle; each stage holds one beat, and a stalled
//   output only stops the stages behind it once they fill up.
// Reset: rst (sync, active high) empties all stages and clears scalar_value.
// ----------------------------------------------------------------------------
module pixel_point_alu import ppa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // configuration: scalar_value
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  // input beats
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] first_pixel, [15:8] second_pixel
  input  logic [4:0]  s_tuser,   // [3:0] opcode, [4] use_scalar
  // result beats
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] result_pixel
  output logic        m_tuser    // [0] divide_by_zero
);

  logic [PIX_W-1:0] scalar_value;

  // Scalar register; the user must write it only while no beat is in flight (not enforced here).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scalar_value <= '0;
    end else if (cfg_valid && cfg_ready) begin
      scalar_value <= cfg_data;
    end
  end

  // Stage 0 is the front; stages 1..N_CELLS are the division cells.
  // Each stage's ready is local: empty, or its successor moves.
  logic      stg_valid [N_CELLS+1];
  logic      stg_ready [N_CELLS+1];
  ppa_beat_t stg_beat  [N_CELLS+1];

  ppa_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .opcode       (s_tuser[3:0]),
    .first_pixel  (s_tdata[7:0]),
    .second_pixel (s_tdata[15:8]),
    .use_scalar   (s_tuser[4]),
    .scalar_value (scalar_value),
    .out_valid    (stg_valid[0]),
    .out_ready    (stg_ready[0]),
    .out_beat     (stg_beat[0])
  );

  // Cell k resolves quotient bit (N_CELLS-k), MSB first.
  for (genvar k = 1; k <= N_CELLS; k++) begin : g_cell
    ppa_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stg_valid[k-1]),
      .in_ready  (stg_ready[k-1]),
      .in_beat   (stg_beat[k-1]),
      .out_valid (stg_valid[k]),
      .out_ready (stg_ready[k]),
      .out_beat  (stg_beat[k])
    );
  end

  // Last cell register is the output register.
  assign stg_ready[N_CELLS] = m_tready;
  assign m_tvalid           = stg_valid[N_CELLS];

  // Non-divides pass the result; divides pick the quotient, or all ones when the divisor was zero.
  always_comb begin
    m_tuser = stg_beat[N_CELLS].dz;
    if (!stg_beat[N_CELLS].is_div) begin
      m_tdata = stg_beat[N_CELLS].result;
    end else if (stg_beat[N_CELLS].dz) begin
      m_tdata = PIX_MAX;
    end else begin
      m_tdata = stg_beat[N_CELLS].aq;
    end
  end

  // -- checks ----------------------------------------------------------------
  a_dz_saturates: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == PIX_MAX)
    else $error("divide_by_zero without saturated result");

  a_dz_only_div: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> stg_beat[N_CELLS].is_div)
    else $error("divide_by_zero flag on a non-divide beat");

  a_front_ready: assert property (@(posedge clk) disable iff (rst)
    !stg_valid[0] |-> s_tready)
    else $error("input stalled while front stage empty");

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> stg_valid[0])
    else $error("accepted beat lost at front stage");

endmodule

FILE: tb/ppa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppa_checker - result predictor and scoreboard for pixel_point_alu
// Tracks scalar_value from the config channel, predicts each pixel
// result as its input beat is accepted, and compares it in order with
// the result beats.
// ----------------------------------------------------------------------------
module ppa_checker import ppa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic [4:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,
  input  logic        m_tuser,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             dz;
  } pixel_result_t;

  logic [PIX_W-1:0] scalar_copy = '0;
  pixel_result_t    pixel_due[$];
  pixel_result_t    due;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic pixel_result_t point_op_pixel(input logic [OP_W-1:0] op,
                                                    input logic [PIX_W-1:0] a,
                                                    input logic [PIX_W-1:0] px,
                                                    input logic             sel,
                                                    input logic [PIX_W-1:0] s);
    logic [PIX_W-1:0]   b;
    logic [PIX_W:0]     sum;
    logic [2*PIX_W-1:0] prod;
    pixel_result_t      r;
    b     = sel ? s : px;
    sum   = {1'b0, a} + {1'b0, b};
    prod  = {{PIX_W{1'b0}}, a} * {{PIX_W{1'b0}}, b};
    r.dz  = 1'b0;
    r.pix = a;  // unknown opcodes pass the pixel through
    case (op)
      OP_SET:       r.pix = s;
      OP_ADD:       r.pix = sum[PIX_W] ? PIX_MAX : sum[PIX_W-1:0];
      OP_SUB:       r.pix = (a > b) ? a - b : '0;
      OP_MUL:       r.pix = prod[2*PIX_W-1:PIX_W];
      OP_DIV: begin
        if (s == '0) begin
          r.pix = PIX_MAX;
          r.dz  = 1'b1;
        end else begin
          r.pix = a / s;
        end
      end
      OP_MAX:       r.pix = (a > b) ? a : b;
      OP_MIN:       r.pix = (a < b) ? a : b;
      OP_AVG:       r.pix = sum[PIX_W:1];
      OP_THRESHOLD: r.pix = (a > s) ? 8'd1 : 8'd0;
      default:      r.pix = a;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      scalar_copy = '0;
      pixel_due.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        scalar_copy = cfg_data;
      if (s_tvalid && s_tready)
        pixel_due.insert(pixel_due.size(),
                         point_op_pixel(s_tuser[3:0], s_tdata[7:0], s_tdata[15:8],
                                        s_tuser[4], scalar_copy));
      if (m_tvalid && m_tready) begin
        if (pixel_due.size() == 0) begin
          $display("%0t: unexpected result beat: pixel %0d dz %0b", $time, m_tdata, m_tuser);
          fail_count++;
        end else begin
          due = pixel_due.pop_front();
          if (m_tdata !== due.pix) begin
            $display("%0t: result_pixel expected %0d actual %0d", $time, due.pix, m_tdata);
            fail_count++;
          end
          if (m_tuser !== due.dz) begin
            $display("%0t: divide_by_zero expected %0b actual %0b", $time, due.dz, m_tuser);
            fail_count++;
          end
        end
      end
    end
    pending = pixel_due.size();
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - regression bench for pixel_point_alu
// Directed corner beats, then randomized pixel beats over several scalar
// settings and three flow-control phases; ppa_checker scores the results.
// ----------------------------------------------------------------------------
module tb import ppa_pkg::*; ();

  // opcodes past the last defined one pass the pixel through
  localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 4'(OP_THRESHOLD) + 4'd1;
  localparam logic [OP_W-1:0] OP_TOP          = '1;

  localparam int CHUNK_BEATS = 72;  // random beats per scalar setting
  localparam int DRAIN_WAIT  = 16;  // outlasts the pipeline latency

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // [7:0] first_pixel, [15:8] second_pixel
  logic [4:0]  s_tuser = '0;   // [3:0] opcode, [4] use_scalar
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // [7:0] result_pixel
  logic        m_tuser;        // [0] divide_by_zero

  int fail_count;
  int pending;

  // per-cycle idle chances, in percent
  int send_idle_pct = 14;
  int recv_idle_pct = 76;

  pixel_point_alu dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  ppa_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // 2 ns clock
  initial begin
    forever #1 clk = ~clk;
  end

  // result side back-pressure, redrawn every cycle
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // hard stop well past the slowest legal run
  initial begin
    #400000;
    $display("pixel_point_alu regression: fail");
    $finish;
  end

  // One input beat. Random idle cycles go in front; valid stays up
  // straight into the next beat when no gap is drawn. tready is looked
  // at on the falling edge, where it has settled.
  task automatic send_pixel(input logic [OP_W-1:0] op, input logic [7:0] a,
                            input logic [7:0] px, input logic sel);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata  <= {px, a};
    s_tuser  <= {sel, op};
    s_tvalid <= 1'b1;
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
  endtask

  // Waits for every outstanding result, then writes scalar_value.
  // Each beat yields a result, so an empty scoreboard means the
  // pipeline is empty.
  task automatic write_scalar(input logic [7:0] value);
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // pixel bytes lean on the edges of the range
  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(9))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd1;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    if ($urandom_range(99) < 8)
      return OP_W'($urandom_range(OP_TOP, OP_FIRST_UNUSED));
    return OP_W'($urandom_range(OP_THRESHOLD, OP_SET));
  endfunction

  task automatic random_chunk(input logic [7:0] scalar);
    write_scalar(scalar);
    repeat (CHUNK_BEATS)
      send_pixel(pick_op(), pick_pixel(), pick_pixel(), 1'($urandom));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // --- directed: scalar still at its reset value of zero ---
    send_pixel(OP_DIV, 8'd200, 8'd7, 1'b0);        // divide by zero flags
    send_pixel(OP_DIV, 8'd0, 8'd0, 1'b1);
    send_pixel(OP_SET, 8'd99, 8'd255, 1'b0);       // set ignores the pixel
    send_pixel(OP_THRESHOLD, 8'd0, 8'd255, 1'b0);  // 0 > 0 is false
    send_pixel(OP_THRESHOLD, 8'd255, 8'd0, 1'b1);
    send_pixel(OP_ADD, 8'd100, 8'd50, 1'b1);       // scalar operand zero

    // --- directed: scalar at full scale ---
    write_scalar(8'd255);
    send_pixel(OP_ADD, 8'd255, 8'd255, 1'b0);      // saturates
    send_pixel(OP_ADD, 8'd0, 8'd0, 1'b0);
    send_pixel(OP_SUB, 8'd0, 8'd255, 1'b0);        // clamps at zero
    send_pixel(OP_SUB, 8'd255, 8'd0, 1'b0);
    send_pixel(OP_SUB, 8'd10, 8'd0, 1'b1);         // minus scalar clamps
    send_pixel(OP_MUL, 8'd255, 8'd255, 1'b0);      // tops out at 254
    send_pixel(OP_MUL, 8'd128, 8'd0, 1'b1);
    send_pixel(OP_DIV, 8'd255, 8'd3, 1'b0);        // 255 / 255
    send_pixel(OP_DIV, 8'd0, 8'd0, 1'b0);
    send_pixel(OP_MAX, 8'd0, 8'd255, 1'b0);
    send_pixel(OP_MIN, 8'd0, 8'd17, 1'b1);
    send_pixel(OP_AVG, 8'd255, 8'd254, 1'b0);      // truncates
    send_pixel(OP_AVG, 8'd255, 8'd0, 1'b1);
    send_pixel(OP_THRESHOLD, 8'd255, 8'd0, 1'b0);  // not strictly above
    send_pixel(OP_SET, 8'd0, 8'd0, 1'b1);
    send_pixel(OP_FIRST_UNUSED, 8'd171, 8'd85, 1'b1);  // passthrough
    send_pixel(OP_TOP, 8'd85, 8'd170, 1'b0);

    // --- directed: scalar of one ---
    write_scalar(8'd1);
    send_pixel(OP_DIV, 8'd200, 8'd0, 1'b0);
    send_pixel(OP_THRESHOLD, 8'd1, 8'd0, 1'b0);

    // --- random, sender mostly busy, receiver mostly stalled ---
    random_chunk(8'd0);
    random_chunk(8'($urandom));
    random_chunk(8'd128);

    // --- random, sender mostly idle, receiver mostly ready ---
    send_idle_pct = 76;
    recv_idle_pct = 14;
    random_chunk(8'd255);
    random_chunk(8'd2);
    random_chunk(8'($urandom));

    // --- random, full rate both ways ---
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_chunk(8'($urandom));
    random_chunk(8'd0);
    random_chunk(8'd255);

    // drain, then give a stray late beat time to show up
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (fail_count == 0)
      $display("pixel_point_alu regression: pass");
    else
      $display("pixel_point_alu regression: fail");
    $finish;
  end

endmodule

FILE: filelist.f
design/ppa_pkg.sv
design/ppa_front.sv
design/ppa_div_cell.sv
design/pixel_point_alu.sv
tb/ppa_checker.sv
tb/tb.sv
